// File: hdl/spq_pkg.sv
package spq_pkg;

	localparam int DEPTH      = 16;
	localparam int LEVELS     = 3;
	localparam int ID_W       = 16;
	localparam int PRIO_W     = 2;
	localparam int STAT_W     = 3;
	localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int MEM_DEPTH  = LEVELS * DEPTH;
	localparam int ADDR_W     = $clog2(MEM_DEPTH);
	localparam int FIFO_DEPTH = 2;
	localparam int FPTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [STAT_W-1:0] {
		ST_ADDED   = 3'd0,
		ST_SERVED  = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_FULL    = 3'd3,
		ST_BADPRIO = 3'd4
	} status_t;

	typedef struct packed {
		status_t             status;
		logic [ADDR_W-1:0]   addr;
		logic [ID_W-1:0]     id;
		logic [PRIO_W-1:0]   prio;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

	typedef struct packed {
		logic reading;
		logic pop;
	} back_stat_t;

	typedef enum logic {
		BK_IDLE,
		BK_READ
	} back_state_t;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
		if (ptr == PTR_W'(DEPTH - 1)) begin
			return '0;
		end
		return ptr + PTR_W'(1);
	endfunction

	function automatic logic [FPTR_W-1:0] fptr_next(input logic [FPTR_W-1:0] ptr);
		if (ptr == FPTR_W'(FIFO_DEPTH - 1)) begin
			return '0;
		end
		return ptr + FPTR_W'(1);
	endfunction

endpackage

// File: hdl/spq_front.sv
module spq_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        func,
	input  logic [spq_pkg::ID_W-1:0]    item_id,
	input  logic [spq_pkg::PRIO_W-1:0]  priority_req,
	input  spq_pkg::fifo_stat_t         fifo_stat,
	output logic                        push,
	output spq_pkg::cmd_t               cmd
);

	logic [spq_pkg::PTR_W-1:0] head_q [spq_pkg::LEVELS];
	logic [spq_pkg::PTR_W-1:0] tail_q [spq_pkg::LEVELS];
	logic [spq_pkg::CNT_W-1:0] lvl_cnt_q [spq_pkg::LEVELS];
	logic [spq_pkg::CNT_W-1:0] total_q;

	logic                      prio_ok;
	logic                      full;
	logic [spq_pkg::LVL_W-1:0] en_lvl;
	logic [spq_pkg::LVL_W-1:0] sv_lvl;
	logic                      found;
	logic                      do_add;
	logic                      do_serve;

	assign push    = start && !fifo_stat.full;
	assign prio_ok = (priority_req != '0) && (32'(priority_req) <= 32'(spq_pkg::LEVELS));
	assign full    = (total_q == spq_pkg::CNT_W'(spq_pkg::DEPTH));
	assign en_lvl  = spq_pkg::LVL_W'(32'(priority_req) - 32'd1);

	// highest nonempty level wins
	always_comb begin
		sv_lvl = '0;
		found  = 1'b0;
		for (int i = 0; i < spq_pkg::LEVELS; i++) begin
			if (lvl_cnt_q[i] != '0) begin
				sv_lvl = spq_pkg::LVL_W'(i);
				found  = 1'b1;
			end
		end
	end

	always_comb begin
		cmd      = '0;
		do_add   = 1'b0;
		do_serve = 1'b0;
		cmd.id   = item_id;
		if (!func) begin
			if (!prio_ok) begin
				cmd.status = spq_pkg::ST_BADPRIO;
			end else if (full) begin
				cmd.status = spq_pkg::ST_FULL;
			end else begin
				cmd.status = spq_pkg::ST_ADDED;
				cmd.addr   = spq_pkg::ADDR_W'(32'(en_lvl) * spq_pkg::DEPTH
					+ 32'(tail_q[en_lvl]));
				do_add     = push;
			end
		end else begin
			if (!found) begin
				cmd.status = spq_pkg::ST_EMPTY;
			end else begin
				cmd.status = spq_pkg::ST_SERVED;
				cmd.addr   = spq_pkg::ADDR_W'(32'(sv_lvl) * spq_pkg::DEPTH
					+ 32'(head_q[sv_lvl]));
				cmd.prio   = spq_pkg::PRIO_W'(32'(sv_lvl) + 32'd1);
				do_serve   = push;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < spq_pkg::LEVELS; i++) begin
				head_q[i]    <= '0;
				tail_q[i]    <= '0;
				lvl_cnt_q[i] <= '0;
			end
			total_q <= '0;
		end else if (do_add) begin
			tail_q[en_lvl]    <= spq_pkg::ptr_next(tail_q[en_lvl]);
			lvl_cnt_q[en_lvl] <= lvl_cnt_q[en_lvl] + spq_pkg::CNT_W'(1);
			total_q           <= total_q + spq_pkg::CNT_W'(1);
		end else if (do_serve) begin
			head_q[sv_lvl]    <= spq_pkg::ptr_next(head_q[sv_lvl]);
			lvl_cnt_q[sv_lvl] <= lvl_cnt_q[sv_lvl] - spq_pkg::CNT_W'(1);
			total_q           <= total_q - spq_pkg::CNT_W'(1);
		end
	end

endmodule

// File: hdl/spq_cmd_fifo.sv
module spq_cmd_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  spq_pkg::cmd_t       wr_cmd,
	input  logic                pop,
	output spq_pkg::cmd_t       rd_cmd,
	output spq_pkg::fifo_stat_t stat
);

	spq_pkg::cmd_t              slot_q [spq_pkg::FIFO_DEPTH];
	logic [spq_pkg::FPTR_W-1:0] wr_ptr_q;
	logic [spq_pkg::FPTR_W-1:0] rd_ptr_q;
	logic [spq_pkg::FCNT_W-1:0] count_q;

	assign rd_cmd     = slot_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == spq_pkg::FCNT_W'(spq_pkg::FIFO_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= spq_pkg::fptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= spq_pkg::fptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + spq_pkg::FCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - spq_pkg::FCNT_W'(1);
			end
		end
	end

endmodule

// File: hdl/spq_back.sv
module spq_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  spq_pkg::fifo_stat_t         fifo_stat,
	input  spq_pkg::cmd_t               cmd,
	output spq_pkg::back_stat_t         back_stat,
	output logic                        done,
	output logic [spq_pkg::STAT_W-1:0]  status,
	output logic [spq_pkg::ID_W-1:0]    served_id,
	output logic [spq_pkg::PRIO_W-1:0]  served_priority
);

	logic [spq_pkg::ID_W-1:0]   mem_q [spq_pkg::MEM_DEPTH];
	logic [spq_pkg::ID_W-1:0]   rd_data_q;
	logic [spq_pkg::PRIO_W-1:0] rd_prio_q;

	spq_pkg::back_state_t state_q;
	spq_pkg::back_state_t state_d;

	logic            pop;
	logic            wr_en;
	logic            rd_en;
	logic            res_valid_q;
	spq_pkg::status_t res_status_q;

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		case (state_q)
			spq_pkg::BK_IDLE: begin
				if (!fifo_stat.empty) begin
					pop = 1'b1;
					if (cmd.status == spq_pkg::ST_SERVED) begin
						rd_en   = 1'b1;
						state_d = spq_pkg::BK_READ;
					end else if (cmd.status == spq_pkg::ST_ADDED) begin
						wr_en = 1'b1;
					end
				end
			end
			spq_pkg::BK_READ: begin
				state_d = spq_pkg::BK_IDLE;
			end
			default: begin
				state_d = spq_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[cmd.addr] <= cmd.id;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[cmd.addr];
			rd_prio_q <= cmd.prio;
		end
	end

	// non-serve results leave in the cycle after the pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= pop && !rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_status_q <= cmd.status;
		end
	end

	assign back_stat.reading = (state_q == spq_pkg::BK_READ);
	assign back_stat.pop     = pop;

	always_comb begin
		if (state_q == spq_pkg::BK_READ) begin
			done            = 1'b1;
			status          = spq_pkg::ST_SERVED;
			served_id       = rd_data_q;
			served_priority = rd_prio_q;
		end else begin
			done            = res_valid_q;
			status          = res_status_q;
			served_id       = '0;
			served_priority = '0;
		end
	end

endmodule

// File: hdl/stable_priority_queue_core.sv
// Flow: with the command queue empty, every request (add, serve or reject) is written into the
// command queue, popped by the back end and registered as a result; a serve reads the ring buffer into a register.
// Throughput: the back end retires one add or reject per cycle; a serve holds off the next pop
// while its read is pending; the two-entry command queue raises busy when the back end lags.
// Reset: arst_n empties every level and the command queue; stored ids are not cleared.
// Results are strobed on done for one cycle; the receiver cannot stall.
module stable_priority_queue_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        func,
	input  logic [spq_pkg::ID_W-1:0]    item_id,
	input  logic [spq_pkg::PRIO_W-1:0]  priority_req,
	output logic                        done,
	output logic [spq_pkg::STAT_W-1:0]  status,
	output logic [spq_pkg::ID_W-1:0]    served_id,
	output logic [spq_pkg::PRIO_W-1:0]  served_priority
);

	spq_pkg::fifo_stat_t fifo_stat;
	spq_pkg::back_stat_t back_stat;
	spq_pkg::cmd_t       wr_cmd;
	spq_pkg::cmd_t       rd_cmd;
	logic                push;

	assign busy = fifo_stat.full;

	spq_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.func         (func),
		.item_id      (item_id),
		.priority_req (priority_req),
		.fifo_stat    (fifo_stat),
		.push         (push),
		.cmd          (wr_cmd)
	);

	spq_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (back_stat.pop),
		.rd_cmd (rd_cmd),
		.stat   (fifo_stat)
	);

	spq_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.fifo_stat       (fifo_stat),
		.cmd             (rd_cmd),
		.back_stat       (back_stat),
		.done            (done),
		.status          (status),
		.served_id       (served_id),
		.served_priority (served_priority)
	);

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != spq_pkg::ST_SERVED) |-> (served_id == '0) && (served_priority == '0))
		else $error("nonzero payload on a non-serve word");

	a_served_prio: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == spq_pkg::ST_SERVED) |-> (served_priority != '0))
		else $error("served word without a priority");

	a_no_pop_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.reading |-> !back_stat.pop)
		else $error("command popped during a pending read");

	a_serve_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.reading |-> $past(back_stat.pop))
		else $error("read state entered without a pop");

endmodule
